FILE: src/asp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants of the arpeggiator step sequencer
// Field widths, register codes, reset values, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package asp_pkg;

    localparam int MAX_PATTERN = 32;

    localparam int PERIOD_W   = 20;
    localparam int LEN_W      = 6;
    localparam int NOTES_W    = 56;
    localparam int NOTE_W     = 7;
    localparam int IDX_W      = 5;
    localparam int NOTE_WORDS = 4;
    localparam int PER_WORD   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 56;
    localparam int DIV_CNT_W  = 3;
    localparam int COUNT_W    = 2;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(IDX_W - 1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 20'd26181;
    localparam logic [LEN_W-1:0]    LEN_RESET     = 6'd8;
    localparam logic [NOTES_W-1:0]  NOTES_A_RESET = 56'd29526165119982125;
    localparam logic [LEN_W-1:0]    LEN_MAX       = LEN_W'(MAX_PATTERN);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_PERIOD    = 3'd0,
        CFG_PATTERN_LENGTH = 3'd1,
        CFG_NOTES_A        = 3'd2,
        CFG_NOTES_B        = 3'd3,
        CFG_NOTES_C        = 3'd4,
        CFG_NOTES_D        = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic eval;
        logic load;
    } asp_cmd_t;

    typedef struct packed {
        logic has_events;
        logic load_ok;
        logic sending_last;
    } asp_status_t;

endpackage
`default_nettype wire

FILE: src/asp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asp_ctrl: tick sequencing controller
// Accepts a tick, runs the remainder unit, triggers evaluation and hands
// each event to the output register in turn.
// ----------------------------------------------------------------------------
module asp_ctrl
    import asp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire asp_status_t status,
    output asp_cmd_t         cmd
);

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                div_cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = status.has_events ? ST_SEND : ST_IDLE;
            end
            ST_SEND:
            begin
                if (status.load_ok && status.sending_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_SEND:
            begin
                cmd.load = status.load_ok;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/asp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asp_dp: arpeggiator datapath
// Configuration registers, sequencer state, a bit-serial remainder unit for
// the step index, event evaluation and the output register.
// ----------------------------------------------------------------------------
module asp_dp
    import asp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  run,
    input  wire asp_cmd_t              cmd,
    output asp_status_t                status,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       note_on,
    output logic [NOTE_W-1:0]          note_number,
    output logic                       last
);

    logic [PERIOD_W-1:0] period_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [NOTES_W-1:0]  notes_reg [NOTE_WORDS];

    logic [PERIOD_W-1:0] position_reg;
    logic [PERIOD_W-1:0] position_next;
    logic [IDX_W-1:0]    index_reg;
    logic [IDX_W-1:0]    index_next;
    logic [NOTE_W-1:0]   held_note_reg;
    logic [NOTE_W-1:0]   held_note_next;
    logic                note_held_reg;
    logic                note_held_next;

    logic                run_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [PERIOD_W-1:0] gate_reg;
    logic [IDX_W-1:0]    div_sh_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [LEN_W-1:0]    rem_next;

    logic                ev0_on_reg;
    logic                ev0_on_next;
    logic [NOTE_W-1:0]   ev0_note_reg;
    logic [NOTE_W-1:0]   ev0_note_next;
    logic [NOTE_W-1:0]   ev1_note_reg;
    logic [NOTE_W-1:0]   ev1_note_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                send_sel_reg;

    logic                out_valid_reg;
    logic                note_on_reg;
    logic [NOTE_W-1:0]   note_number_reg;
    logic                last_reg;

    logic [LEN_W-1:0]    len_sat;
    logic [PERIOD_W+1:0] gate_sum;
    logic [LEN_W-1:0]    rem_shift;
    logic [NOTE_W-1:0]   note_list [MAX_PATTERN];
    logic [NOTE_W-1:0]   note_sel;
    logic                step_end;
    logic                sending_last;
    logic                load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RESET;
            length_reg   <= LEN_RESET;
            notes_reg[0] <= NOTES_A_RESET;
            notes_reg[1] <= '0;
            notes_reg[2] <= '0;
            notes_reg[3] <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_STEP_PERIOD:    period_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_PATTERN_LENGTH: length_reg   <= cfg_data[LEN_W-1:0];
                CFG_NOTES_A:        notes_reg[0] <= cfg_data[NOTES_W-1:0];
                CFG_NOTES_B:        notes_reg[1] <= cfg_data[NOTES_W-1:0];
                CFG_NOTES_C:        notes_reg[2] <= cfg_data[NOTES_W-1:0];
                CFG_NOTES_D:        notes_reg[3] <= cfg_data[NOTES_W-1:0];
                default:            period_reg   <= period_reg;
            endcase
        end
    end

    assign len_sat  = (length_reg > LEN_MAX) ? LEN_MAX : length_reg;
    assign gate_sum = {2'b00, period_reg} + {1'b0, period_reg, 1'b0};

    assign rem_shift = {rem_reg[LEN_W-2:0], div_sh_reg[IDX_W-1]};
    assign rem_next  = (rem_shift >= len_reg) ? (rem_shift - len_reg) : rem_shift;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            run_reg    <= run;
            len_reg    <= len_sat;
            gate_reg   <= gate_sum[PERIOD_W+1:2];
            div_sh_reg <= index_reg;
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            div_sh_reg <= {div_sh_reg[IDX_W-2:0], 1'b0};
            rem_reg    <= rem_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            note_list[i] = notes_reg[i / PER_WORD][NOTE_W * (i % PER_WORD) +: NOTE_W];
        end
    end

    assign note_sel = note_list[rem_reg[IDX_W-1:0]];
    assign step_end = ({1'b0, position_reg} + 21'd1) >= {1'b0, period_reg};

    always_comb
    begin
        count_next     = '0;
        ev0_on_next    = 1'b0;
        ev0_note_next  = held_note_reg;
        ev1_note_next  = note_sel;
        held_note_next = held_note_reg;
        note_held_next = note_held_reg;
        position_next  = position_reg;
        index_next     = index_reg;
        if (!run_reg)
        begin
            if (note_held_reg)
            begin
                count_next     = COUNT_W'(1);
                note_held_next = 1'b0;
            end
        end
        else if (len_reg != '0)
        begin
            if (position_reg == '0)
            begin
                held_note_next = note_sel;
                note_held_next = 1'b1;
                if (note_held_reg)
                begin
                    count_next = COUNT_W'(2);
                end
                else
                begin
                    count_next    = COUNT_W'(1);
                    ev0_on_next   = 1'b1;
                    ev0_note_next = note_sel;
                end
            end
            else if ((position_reg == gate_reg) && note_held_reg)
            begin
                count_next     = COUNT_W'(1);
                note_held_next = 1'b0;
            end
            if (step_end)
            begin
                position_next = '0;
                index_next    = ((rem_reg + LEN_W'(1)) == len_reg) ? '0
                                : (rem_reg[IDX_W-1:0] + IDX_W'(1));
            end
            else
            begin
                position_next = position_reg + PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            index_reg     <= '0;
            held_note_reg <= '0;
            note_held_reg <= 1'b0;
        end
        else if (cmd.eval)
        begin
            position_reg  <= position_next;
            index_reg     <= index_next;
            held_note_reg <= held_note_next;
            note_held_reg <= note_held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            ev0_on_reg   <= ev0_on_next;
            ev0_note_reg <= ev0_note_next;
            ev1_note_reg <= ev1_note_next;
            count_reg    <= count_next;
        end
    end

    assign sending_last = send_sel_reg || (count_reg == COUNT_W'(1));
    assign load_ok      = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                send_sel_reg <= 1'b0;
            end
            else if (cmd.load)
            begin
                send_sel_reg <= 1'b1;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            note_on_reg     <= send_sel_reg ? 1'b1 : ev0_on_reg;
            note_number_reg <= send_sel_reg ? ev1_note_reg : ev0_note_reg;
            last_reg        <= sending_last;
        end
    end

    assign status.has_events   = (count_next != '0);
    assign status.load_ok      = load_ok;
    assign status.sending_last = sending_last;

    assign out_valid   = out_valid_reg;
    assign note_on     = note_on_reg;
    assign note_number = note_number_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire

FILE: src/arpeggiator_step_sequencer_core.sv
`default_nettype none
// A tick occupies the core through the remainder unit and evaluation, and then
// until its events, if any, are loaded, plus any time the output is stalled.
// The first event follows the tick transfer once the bit-serial remainder of
// step index by pattern length is done.
// A new tick is taken while the last event still waits in the output register.
// Reset loads the default tempo and pattern and clears position and held note.
// ----------------------------------------------------------------------------
// arpeggiator_step_sequencer_core: arpeggiator step sequencer top level
// Joins the tick controller and the datapath.
// ----------------------------------------------------------------------------
module arpeggiator_step_sequencer_core
    import asp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  run,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       note_on,
    output logic [NOTE_W-1:0]          note_number,
    output logic                       last
);

    asp_cmd_t    cmd;
    asp_status_t status;

    asp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    asp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .run         (run),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .note_on     (note_on),
        .note_number (note_number),
        .last        (last)
    );

endmodule
`default_nettype wire

FILE: src/asp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asp_checker: port-level checks of the arpeggiator step sequencer
// Watches the handshakes and the event order seen on the top-level ports.
// ----------------------------------------------------------------------------
module asp_checker
    import asp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic                  note_on,
    input wire logic [NOTE_W-1:0]     note_number,
    input wire logic                  last
);

    // A note on always closes the events of its tick.
    a_note_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && note_on |-> last)
        else $error("note on transfer without last marker");

    // The second event of a tick follows its first without a gap.
    a_pair_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap between events of one tick");

    // Each accepted tick is worked on before another is taken.
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("tick taken while the previous one is in progress");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(note_on)
        && $stable(note_number) && $stable(last))
        else $error("stalled result changed");

endmodule

bind arpeggiator_step_sequencer_core asp_checker u_asp_checker (.*);
`default_nettype wire
